[hw/rtl/csm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSS stream minifier package
// Shared types, character codes and byte classifiers.
// ----------------------------------------------------------------------------
package csm_pkg;

  // Entries in the queue between the front and back sides
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Most result items one input byte can produce
  localparam int unsigned MAX_ITEMS   = 3;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_Z   = 8'h5A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [1:0]                cnt;
    item_t [MAX_ITEMS-1:0]     items;
  } entry_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= CH_UC_A) && (c <= CH_UC_Z)) || ((c >= CH_LC_A) && (c <= CH_LC_Z));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_COLON) ||
           (c == CH_SEMI) || (c == CH_COMMA) || (c == CH_GT) ||
           (c == CH_TILDE) || (c == CH_LPAREN) || (c == CH_RPAREN);
  endfunction

endpackage

[hw/rtl/csm_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSS minifier input channel
// Valid/ready channel carrying one text byte per item.
// ----------------------------------------------------------------------------
interface csm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

[hw/rtl/csm_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSS minifier output channel
// Valid/ready channel carrying one minified byte or end marker per item.
// ----------------------------------------------------------------------------
interface csm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       last;

  modport source (output valid, output out_byte, output byte_valid, output last,
                  input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input last,
                  output ready);
endinterface

[hw/rtl/csm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSS minifier front end
// Accepts text bytes, tracks lexer state one byte behind the input and
// packs the output items that an input byte yields, if any, into one queue entry.
// ----------------------------------------------------------------------------
module csm_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  csm_in_if.sink           in_i,
  input  logic             full_i,
  output logic             push_o,
  output csm_pkg::entry_t  entry_o
);

  logic [7:0] la_byte_q, la_byte_d;
  logic       la_valid_q, la_valid_d;
  logic [7:0] held_byte_q, held_byte_d;
  logic       held_valid_q, held_valid_d;
  logic [7:0] prior_q, prior_d;
  logic       at_start_q, at_start_d;
  logic       comment_q, comment_d;
  logic       skip_q, skip_d;
  logic [7:0] quote_q, quote_d;
  logic       esc_q, esc_d;
  logic       gap_q, gap_d;
  logic       unit_q, unit_d;

  logic accept;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;

  always_comb begin
    logic [7:0]      c;
    logic [7:0]      nx;
    logic [7:0]      hb;
    logic            hv;
    logic            drop;
    logic            esc_n;
    logic            live;
    logic [1:0]      np;
    logic [1:0][7:0] pb;
    logic [1:0]      k;
    csm_pkg::entry_t ent;

    la_byte_d    = la_byte_q;
    la_valid_d   = la_valid_q;
    prior_d      = prior_q;
    at_start_d   = at_start_q;
    comment_d    = comment_q;
    skip_d       = skip_q;
    quote_d      = quote_q;
    esc_d        = esc_q;
    gap_d        = gap_q;
    unit_d       = unit_q;

    c     = la_byte_q;
    nx    = in_i.in_byte;
    hb    = held_byte_q;
    hv    = held_valid_q;
    drop  = 1'b0;
    esc_n = 1'b0;
    live  = 1'b1;
    np    = 2'd0;
    pb    = '0;
    k     = 2'd0;
    ent   = '0;

    if (accept && la_valid_q) begin
      at_start_d = 1'b0;
      prior_d    = c;
      if (skip_q) begin
        skip_d = 1'b0;
      end else begin
        if (unit_q) begin
          if (csm_pkg::is_alpha(c) || (c == csm_pkg::CH_PCT)) begin
            live = 1'b0;
          end else begin
            unit_d = 1'b0;
          end
        end
        if (live) begin
          if (comment_q) begin
            if ((c == csm_pkg::CH_STAR) && (nx == csm_pkg::CH_SLASH)) begin
              comment_d = 1'b0;
              skip_d    = 1'b1;
            end
          end else if ((quote_q == csm_pkg::CH_NUL) && (c == csm_pkg::CH_SLASH) &&
                       (nx == csm_pkg::CH_STAR)) begin
            comment_d = 1'b1;
            skip_d    = 1'b1;
          end else if (quote_q != csm_pkg::CH_NUL) begin
            np    = 2'd1;
            pb[0] = c;
            esc_n = !esc_q && (c == csm_pkg::CH_BSLASH);
            esc_d = esc_n;
            if (!esc_n && (c == quote_q)) begin
              quote_d = csm_pkg::CH_NUL;
            end
          end else if ((c == csm_pkg::CH_DQUOTE) || (c == csm_pkg::CH_SQUOTE)) begin
            quote_d = c;
            esc_d   = 1'b0;
            np      = 2'd1;
            pb[0]   = c;
          end else if (csm_pkg::is_ws(c)) begin
            gap_d = 1'b1;
          end else if (csm_pkg::is_punct(c)) begin
            drop = (c == csm_pkg::CH_RBRACE) && held_valid_q &&
                   (held_byte_q == csm_pkg::CH_SEMI);
            if ((c == csm_pkg::CH_LPAREN) && held_valid_q &&
                ((held_byte_q == csm_pkg::CH_PLUS) || (held_byte_q == csm_pkg::CH_MINUS))) begin
              np    = 2'd2;
              pb[0] = csm_pkg::CH_SPACE;
              pb[1] = c;
            end else begin
              np    = 2'd1;
              pb[0] = c;
            end
            gap_d = 1'b0;
          end else begin
            // Insert a separating space unless the held byte already separates
            if (gap_q && held_valid_q && (held_byte_q != csm_pkg::CH_LBRACE) &&
                (held_byte_q != csm_pkg::CH_COLON) && (held_byte_q != csm_pkg::CH_COMMA) &&
                (held_byte_q != csm_pkg::CH_SEMI)) begin
              np    = 2'd1;
              pb[0] = csm_pkg::CH_SPACE;
            end
            gap_d = 1'b0;
            if ((c == csm_pkg::CH_ZERO) &&
                (csm_pkg::is_alpha(nx) || (nx == csm_pkg::CH_PCT)) &&
                (at_start_q || (!csm_pkg::is_digit(prior_q) && (prior_q != csm_pkg::CH_DOT)))) begin
              pb[np[0]] = csm_pkg::CH_ZERO;
              unit_d    = 1'b1;
            end else begin
              pb[np[0]] = c;
            end
            np = np + 2'd1;
          end
        end
      end
    end

    // Each put sends the held byte on and holds the new one
    if (drop) begin
      hv = 1'b0;
    end
    for (int i = 0; i < 2; i++) begin
      if (2'(i) < np) begin
        if (hv) begin
          ent.items[k] = '{out_byte: hb, byte_valid: 1'b1, last: 1'b0};
          k = k + 2'd1;
        end
        hb = pb[i];
        hv = 1'b1;
      end
    end
    held_byte_d  = hb;
    held_valid_d = hv;

    if (accept) begin
      if (nx != csm_pkg::CH_NUL) begin
        la_byte_d  = nx;
        la_valid_d = 1'b1;
      end else begin
        // Terminator: flush the held byte as the final item and restart
        if (hv) begin
          ent.items[k] = '{out_byte: hb, byte_valid: 1'b1, last: 1'b1};
        end else begin
          ent.items[k] = '{out_byte: csm_pkg::CH_NUL, byte_valid: 1'b0, last: 1'b1};
        end
        k            = k + 2'd1;
        la_byte_d    = csm_pkg::CH_NUL;
        la_valid_d   = 1'b0;
        held_byte_d  = csm_pkg::CH_NUL;
        held_valid_d = 1'b0;
        prior_d      = csm_pkg::CH_NUL;
        at_start_d   = 1'b1;
        comment_d    = 1'b0;
        skip_d       = 1'b0;
        quote_d      = csm_pkg::CH_NUL;
        esc_d        = 1'b0;
        gap_d        = 1'b0;
        unit_d       = 1'b0;
      end
    end

    ent.cnt = k;
    entry_o = ent;
    push_o  = accept && (k != 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      la_byte_q    <= '0;
      la_valid_q   <= 1'b0;
      held_byte_q  <= '0;
      held_valid_q <= 1'b0;
      prior_q      <= '0;
      at_start_q   <= 1'b1;
      comment_q    <= 1'b0;
      skip_q       <= 1'b0;
      quote_q      <= '0;
      esc_q        <= 1'b0;
      gap_q        <= 1'b0;
      unit_q       <= 1'b0;
    end else begin
      la_byte_q    <= la_byte_d;
      la_valid_q   <= la_valid_d;
      held_byte_q  <= held_byte_d;
      held_valid_q <= held_valid_d;
      prior_q      <= prior_d;
      at_start_q   <= at_start_d;
      comment_q    <= comment_d;
      skip_q       <= skip_d;
      quote_q      <= quote_d;
      esc_q        <= esc_d;
      gap_q        <= gap_d;
      unit_q       <= unit_d;
    end
  end

endmodule

[hw/rtl/csm_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSS minifier entry queue
// Small register queue of output entries between the front and back sides.
// ----------------------------------------------------------------------------
module csm_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  csm_pkg::entry_t  entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             head_valid_o,
  output csm_pkg::entry_t  head_o
);

  csm_pkg::entry_t                   mem_q [csm_pkg::QUEUE_DEPTH];
  logic [csm_pkg::QPTR_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [csm_pkg::QPTR_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [csm_pkg::QCNT_W-1:0]        count_q, count_d;

  assign full_o       = (count_q == csm_pkg::QCNT_W'(csm_pkg::QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  function automatic logic [csm_pkg::QPTR_W-1:0] ptr_inc(input logic [csm_pkg::QPTR_W-1:0] p);
    if (p == csm_pkg::QPTR_W'(csm_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("queue pushed while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("queue popped while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= csm_pkg::QCNT_W'(csm_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");
`endif

endmodule

[hw/rtl/csm_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSS minifier back end
// Walks the items of the head queue entry and issues one per cycle, while
// the output is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module csm_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  csm_pkg::entry_t  head_i,
  output logic             pop_o,
  csm_out_if.source        out_o
);

  logic [1:0]      idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  csm_pkg::item_t  item_q;
  logic            load;
  logic            last_idx;

  assign load     = head_valid_i && (!out_valid_q || out_o.ready);
  assign last_idx = (idx_q == (head_i.cnt - 2'd1));
  assign pop_o    = load && last_idx;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      idx_d       = last_idx ? 2'd0 : (idx_q + 2'd1);
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Payload register: refill only when the stage is empty or drains
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= head_i.items[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_byte   = item_q.out_byte;
  assign out_o.byte_valid = item_q.byte_valid;
  assign out_o.last       = item_q.last;

`ifndef NO_ASSERTIONS
  a_idx_in_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> (idx_q < head_i.cnt))
    else $error("item index beyond head entry");

  a_entry_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> (head_i.cnt != 2'd0))
    else $error("empty entry in queue");

  a_marker_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (item_q.byte_valid || item_q.last))
    else $error("bare end marker without last");

  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_valid_i |-> (idx_q == 2'd0))
    else $error("item index left mid-entry");
`endif

endmodule

[hw/rtl/css_stream_minifier_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSS stream minifier
// Streaming CSS minifier: one text byte in, minified bytes out.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle and issues at most one result item
// per cycle. Output runs one byte behind input: a byte is held until the next
// one arrives so a ';' before '}' can be dropped and a space can be inserted.
// A byte that yields two results (a space plus a token) or the zero terminator
// (up to three results) occupies the single-item output stage for each of its
// results in turn, so on a steady stream of such bytes the input must wait.
// The two-entry queue between the lexer front end and the output
// side lets the input run on through bytes that yield nothing (whitespace,
// comments) while the output side catches up; the input also stalls whenever
// the output side is held back and the queue fills.
// Byte 0 ends a text, flushes the held byte with last set (a bare end marker
// for empty output) and restarts the lexer for the next text.
// ----------------------------------------------------------------------------
module css_stream_minifier_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  csm_in_if.sink    in_i,
  csm_out_if.source out_o
);

  logic            push;
  logic            full;
  logic            pop;
  logic            head_valid;
  csm_pkg::entry_t entry;
  csm_pkg::entry_t head;

  csm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (entry)
  );

  csm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (entry),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  csm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

[tb/css_stream_minifier_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSS stream minifier testbench
// Streams short CSS texts through the minifier with random idle cycles on both
// channels. Every output item is checked against a byte-level model of the
// minifier that runs one byte behind the input.
// ----------------------------------------------------------------------------
module css_stream_minifier_top_test;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 32;
  localparam int RANDOM_BYTES   = 220;
  localparam string SEP_CHARS   = "{}:;,>~()";

  logic clk_i = 1'b0;
  logic rst_ni;

  csm_in_if  in_if ();
  csm_out_if out_if ();

  css_stream_minifier_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #4 clk_i = ~clk_i;

  // Minifier model state
  logic [7:0] la_byte;
  bit         la_vld;
  logic [7:0] held_byte;
  bit         held_vld;
  logic [7:0] prev_raw;
  bit         text_start;
  bit         in_cmt;
  bit         drop_next;
  logic [7:0] quote_ch;
  bit         esc_pend;
  bit         ws_pend;
  bit         unit_skip;
  int         step_cnt;

  csm_pkg::item_t minified_q[$];
  logic [7:0]     text_q[$];
  int             mismatch_cnt = 0;
  int             idle_cycles  = 0;
  int             bytes_sent   = 0;
  bit             steady       = 1'b0;

  function automatic bit blank_char(logic [7:0] c);
    return (c == csm_pkg::CH_SPACE) || (c >= csm_pkg::CH_TAB && c <= csm_pkg::CH_CR);
  endfunction

  function automatic bit letter_char(logic [7:0] c);
    return (c >= csm_pkg::CH_UC_A && c <= csm_pkg::CH_UC_Z) ||
           (c >= csm_pkg::CH_LC_A && c <= csm_pkg::CH_LC_Z);
  endfunction

  function automatic bit digit_char(logic [7:0] c);
    return c >= csm_pkg::CH_ZERO && c <= csm_pkg::CH_NINE;
  endfunction

  function automatic bit sep_char(logic [7:0] c);
    for (int i = 0; i < SEP_CHARS.len(); i++)
      if (c == SEP_CHARS[i]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void clear_state();
    la_byte    = '0;
    la_vld     = 1'b0;
    held_byte  = '0;
    held_vld   = 1'b0;
    prev_raw   = '0;
    text_start = 1'b1;
    in_cmt     = 1'b0;
    drop_next  = 1'b0;
    quote_ch   = csm_pkg::CH_NUL;
    esc_pend   = 1'b0;
    ws_pend    = 1'b0;
    unit_skip  = 1'b0;
  endfunction

  function automatic void emit(logic [7:0] b, bit v, bit l);
    if (step_cnt < csm_pkg::MAX_ITEMS) begin
      minified_q.push_back(csm_pkg::item_t'{b, v, l});
      step_cnt++;
    end
  endfunction

  // Release the held byte and hold b, so a ';' or a sign can still be seen
  function automatic void hold(logic [7:0] b);
    if (held_vld) emit(held_byte, 1'b1, 1'b0);
    held_byte = b;
    held_vld  = 1'b1;
  endfunction

  function automatic void lex_char(logic [7:0] c, logic [7:0] nx);
    bit         first = text_start;
    logic [7:0] pb    = prev_raw;
    text_start = 1'b0;
    prev_raw   = c;
    if (drop_next) begin
      drop_next = 1'b0;
      return;
    end
    if (unit_skip) begin
      if (letter_char(c) || c == csm_pkg::CH_PCT) return;
      unit_skip = 1'b0;
    end
    if (in_cmt) begin
      if (c == csm_pkg::CH_STAR && nx == csm_pkg::CH_SLASH) begin
        in_cmt    = 1'b0;
        drop_next = 1'b1;
      end
      return;
    end
    if (quote_ch == csm_pkg::CH_NUL && c == csm_pkg::CH_SLASH && nx == csm_pkg::CH_STAR) begin
      in_cmt    = 1'b1;
      drop_next = 1'b1;
      return;
    end
    if (quote_ch != csm_pkg::CH_NUL) begin
      hold(c);
      esc_pend = !esc_pend && c == csm_pkg::CH_BSLASH;
      if (!esc_pend && c == quote_ch) quote_ch = csm_pkg::CH_NUL;
      return;
    end
    if (c == csm_pkg::CH_DQUOTE || c == csm_pkg::CH_SQUOTE) begin
      quote_ch = c;
      esc_pend = 1'b0;
      hold(c);
      return;
    end
    if (blank_char(c)) begin
      ws_pend = 1'b1;
      return;
    end
    if (sep_char(c)) begin
      if (c == csm_pkg::CH_RBRACE && held_vld && held_byte == csm_pkg::CH_SEMI)
        held_vld = 1'b0;
      if (c == csm_pkg::CH_LPAREN && held_vld &&
          (held_byte == csm_pkg::CH_PLUS || held_byte == csm_pkg::CH_MINUS))
        hold(csm_pkg::CH_SPACE);
      hold(c);
      ws_pend = 1'b0;
      return;
    end
    if (ws_pend && held_vld && held_byte != csm_pkg::CH_LBRACE &&
        held_byte != csm_pkg::CH_COLON && held_byte != csm_pkg::CH_COMMA &&
        held_byte != csm_pkg::CH_SEMI)
      hold(csm_pkg::CH_SPACE);
    ws_pend = 1'b0;
    if (c == csm_pkg::CH_ZERO && (letter_char(nx) || nx == csm_pkg::CH_PCT) &&
        (first || (!digit_char(pb) && pb != csm_pkg::CH_DOT))) begin
      hold(csm_pkg::CH_ZERO);
      unit_skip = 1'b1;
      return;
    end
    hold(c);
  endfunction

  // Work out the items that one accepted text byte releases
  function automatic void minify_byte(logic [7:0] x);
    step_cnt = 0;
    if (x != csm_pkg::CH_NUL) begin
      if (la_vld) lex_char(la_byte, x);
      la_byte = x;
      la_vld  = 1'b1;
    end else begin
      if (la_vld) lex_char(la_byte, csm_pkg::CH_NUL);
      if (held_vld) emit(held_byte, 1'b1, 1'b1);
      else emit(8'h00, 1'b0, 1'b1);
      clear_state();
    end
  endfunction

  function automatic void check_item();
    csm_pkg::item_t want;
    if (minified_q.size() == 0) begin
      $error("unexpected item: out_byte %02h byte_valid %0b last %0b",
             out_if.out_byte, out_if.byte_valid, out_if.last);
      mismatch_cnt++;
      return;
    end
    want = minified_q.pop_front();
    if (out_if.out_byte !== want.out_byte) begin
      $error("out_byte: expected %02h, got %02h", want.out_byte, out_if.out_byte);
      mismatch_cnt++;
    end
    if (out_if.byte_valid !== want.byte_valid) begin
      $error("byte_valid: expected %0b, got %0b", want.byte_valid, out_if.byte_valid);
      mismatch_cnt++;
    end
    if (out_if.last !== want.last) begin
      $error("last: expected %0b, got %0b", want.last, out_if.last);
      mismatch_cnt++;
    end
  endfunction

  // Predict on input acceptance before checking output in the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      idle_cycles++;
      if (in_if.valid && in_if.ready) begin
        minify_byte(in_if.in_byte);
        idle_cycles = 0;
      end
      if (out_if.valid && out_if.ready) begin
        check_item();
        idle_cycles = 0;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("** css_stream_minifier_top: FAILED **");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin
    out_if.ready <= steady || ($urandom_range(0, 99) >= 10);
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_byte(logic [7:0] b);
    while (!steady && $urandom_range(0, 99) < 10) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    do @(posedge clk_i); while (!in_if.ready);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(csm_pkg::CH_NUL);
  endtask

  function automatic void add(logic [7:0] b);
    text_q.push_back(b);
  endfunction

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1)) return 8'(csm_pkg::CH_UC_A + $urandom_range(0, 25));
    return 8'(csm_pkg::CH_LC_A + $urandom_range(0, 25));
  endfunction

  function automatic void add_ws();
    int idx;
    idx = $urandom_range(0, 5);
    add(idx == 0 ? csm_pkg::CH_SPACE : 8'(csm_pkg::CH_TAB + idx - 1));
  endfunction

  function automatic void add_ident();
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 5))
        0:       add(csm_pkg::CH_MINUS);
        1:       add(8'(csm_pkg::CH_ZERO + $urandom_range(0, 9)));
        default: add(rand_letter());
      endcase
    end
  endfunction

  function automatic void add_number();
    case ($urandom_range(0, 3))
      0: add(csm_pkg::CH_ZERO);
      1: begin
        add(8'(csm_pkg::CH_ZERO + $urandom_range(1, 9)));
        add(csm_pkg::CH_ZERO);
      end
      2: begin
        add(csm_pkg::CH_DOT);
        add(csm_pkg::CH_ZERO);
      end
      default: begin
        add(csm_pkg::CH_ZERO);
        add(csm_pkg::CH_DOT);
        add(8'(csm_pkg::CH_ZERO + $urandom_range(0, 9)));
      end
    endcase
    case ($urandom_range(0, 3))
      0: add(csm_pkg::CH_PCT);
      1: ;
      default: repeat ($urandom_range(1, 2)) add(rand_letter());
    endcase
  endfunction

  // Append one well-formed piece of CSS, or now and then a broken one
  function automatic void add_fragment();
    logic [7:0] q;
    case ($urandom_range(0, 11))
      0, 11: repeat ($urandom_range(1, 3)) add_ws();
      1: add(SEP_CHARS[$urandom_range(0, SEP_CHARS.len() - 1)]);
      2: add_ident();
      3: add_number();
      4: begin
        q = $urandom_range(0, 1) ? csm_pkg::CH_DQUOTE : csm_pkg::CH_SQUOTE;
        add(q);
        repeat ($urandom_range(0, 4)) begin
          case ($urandom_range(0, 4))
            0: add(csm_pkg::CH_SPACE);
            1: begin
              add(csm_pkg::CH_BSLASH);
              add($urandom_range(0, 1) ? q : csm_pkg::CH_BSLASH);
            end
            2: add(q == csm_pkg::CH_DQUOTE ? csm_pkg::CH_SQUOTE : csm_pkg::CH_DQUOTE);
            3: add($urandom_range(0, 1) ? csm_pkg::CH_STAR : csm_pkg::CH_SLASH);
            default: add(rand_letter());
          endcase
        end
        if ($urandom_range(0, 4) != 0) add(q);
      end
      5: begin
        add(csm_pkg::CH_SLASH);
        add(csm_pkg::CH_STAR);
        repeat ($urandom_range(0, 3)) begin
          case ($urandom_range(0, 3))
            0: add(csm_pkg::CH_STAR);
            1: add(csm_pkg::CH_SLASH);
            2: add(csm_pkg::CH_SPACE);
            default: add(rand_letter());
          endcase
        end
        if ($urandom_range(0, 5) != 0) begin
          add(csm_pkg::CH_STAR);
          add(csm_pkg::CH_SLASH);
        end
      end
      6: begin
        add($urandom_range(0, 1) ? csm_pkg::CH_PLUS : csm_pkg::CH_MINUS);
        if ($urandom_range(0, 2) == 0) add_ws();
        add(csm_pkg::CH_LPAREN);
      end
      7: begin
        add(csm_pkg::CH_SEMI);
        if ($urandom_range(0, 1)) add_ws();
        add(csm_pkg::CH_RBRACE);
      end
      8, 9: begin
        add_ident();
        if ($urandom_range(0, 1)) add_ws();
        add(csm_pkg::CH_LBRACE);
        add_ident();
        add(csm_pkg::CH_COLON);
        if ($urandom_range(0, 1)) add_ws();
        add_number();
        if ($urandom_range(0, 1)) add_ws();
        add(csm_pkg::CH_SEMI);
        if ($urandom_range(0, 1)) add_ws();
        add(csm_pkg::CH_RBRACE);
      end
      default: add(8'($urandom_range(1, 255)));
    endcase
  endfunction

  // Empty output gives a bare end marker
  task automatic test_empty_text();
    send_byte(csm_pkg::CH_NUL);
  endtask

  // Opener and closer must not share a '*'; a gap after a comment still counts
  task automatic test_comments();
    send_text("a/*/x*/ b");
  endtask

  // Escaped quote, gap before a string, and a string left open at the end
  task automatic test_strings();
    send_text("a '\\''\"x");
  endtask

  // Separators, ';' before '}', zero with a unit, sign before '(' at the end
  task automatic test_punctuation();
    send_text("a ; }+(0px -(");
  endtask

  task automatic test_high_bytes();
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(csm_pkg::CH_NUL);
  endtask

  task automatic test_random_texts();
    int start;
    int text_no;
    start   = bytes_sent;
    text_no = 0;
    while (bytes_sent - start < RANDOM_BYTES) begin
      // hold both sides busy for a stretch of texts
      steady = (text_no >= 6 && text_no < 12);
      text_q.delete();
      repeat ($urandom_range(0, 5)) add_fragment();
      foreach (text_q[i]) send_byte(text_q[i]);
      send_byte(csm_pkg::CH_NUL);
      text_no++;
    end
    steady = 1'b0;
  endtask

  initial begin
    clear_state();
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.in_byte = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_text();
    test_comments();
    test_strings();
    test_punctuation();
    test_high_bytes();
    test_random_texts();

    in_if.valid <= 1'b0;
    while (minified_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && minified_q.size() == 0) begin
      $display("** css_stream_minifier_top: PASSED **");
    end else begin
      $display("** css_stream_minifier_top: FAILED **");
    end
    $finish;
  end

endmodule
